### hw/rtl/ipts_pkg.sv
package ipts_pkg;

  localparam int HDR_BYTES   = 40;
  localparam int OPT_BYTES   = 16;
  localparam int CHAIN_CELLS = HDR_BYTES + OPT_BYTES;

  localparam logic [7:0] NH_DSTOPT   = 8'h3c;
  localparam logic [7:0] OPT_HDR_LEN = 8'h01;
  localparam logic [7:0] OPT_LEN     = 8'h0c;

  typedef logic [7:0] byte_t;
  typedef byte_t [CHAIN_CELLS-1:0] chain_bytes_t;
  typedef logic [CHAIN_CELLS-1:0] chain_mask_t;

  // shift: every cell takes its right-hand neighbor (the last cell takes zero)
  // fill:  the last header cell takes the incoming word instead
  typedef struct packed {
    logic shift;
    logic fill;
  } chain_ctl_t;

endpackage

### hw/rtl/ipts_cell.sv
module ipts_cell (
  input  logic          clk,
  input  logic          shift,
  input  logic          load,
  input  ipts_pkg::byte_t shift_in,
  input  ipts_pkg::byte_t load_val,
  output ipts_pkg::byte_t q
);
  import ipts_pkg::*;

  // load wins over shift
  always_ff @(posedge clk) begin
    if (load) begin
      q <= load_val;
    end else if (shift) begin
      q <= shift_in;
    end
  end

endmodule

### hw/rtl/ipts_chain.sv
module ipts_chain (
  input  logic                     clk,
  input  ipts_pkg::chain_ctl_t     ctl,
  input  ipts_pkg::byte_t          fill_byte,
  input  ipts_pkg::chain_mask_t    load_en,
  input  ipts_pkg::chain_bytes_t   load_val,
  output ipts_pkg::chain_bytes_t   cell_q
);
  import ipts_pkg::*;

  for (genvar i = 0; i < CHAIN_CELLS; i++) begin : g_cell
    byte_t nbr;

    if (i == HDR_BYTES - 1) begin : g_tail
      assign nbr = ctl.fill ? fill_byte : cell_q[i+1];
    end else if (i == CHAIN_CELLS - 1) begin : g_end
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_q[i+1];
    end

    ipts_cell u_cell (
      .clk      (clk),
      .shift    (ctl.shift),
      .load     (load_en[i]),
      .shift_in (nbr),
      .load_val (load_val[i]),
      .q        (cell_q[i])
    );
  end

endmodule

### hw/rtl/ipv6_timestamp_option_inserter.sv
// IPv6 timestamp option inserter.
// Input channel (in_valid/in_stall): one packet word per transfer, data_byte
// with last_byte on the final word, plus the current time (time_seconds,
// time_micros) that is sampled on the word completing the 40-byte header.
// Output channel (out_valid/out_stall): out_byte, out_last, stamped.
// Configuration: cfg_write/cfg_index/cfg_data. The user must see that it is
// written only while idle; the block itself does not enforce this. The 40
// header words shift into a row of 56 byte cells; no output is produced
// while they arrive. In the cycle after the last one, the stamp decision,
// if it hits, patches payload length and next header in place and loads
// the 16 option words into the cells behind the header. The row then
// shifts out one word per cycle from its head while the output is not
// stalled: 40 or 56 words. A packet shorter than 40 words first shifts
// idle until its first word reaches the head. Remaining words pass through
// cell 0 at one word per cycle while the output is not stalled. The input
// is stalled during decision and header emission. A stalled output holds
// its word and the whole row. Reset returns to header capture with
// sequence number zero and the default register values.
module ipv6_timestamp_option_inserter (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic [31:0] time_seconds,
  input  logic [19:0] time_micros,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        stamped
);
  import ipts_pkg::*;

  localparam logic [1:0] REG_PREFIX0 = 2'd0;
  localparam logic [1:0] REG_PREFIX1 = 2'd1;
  localparam logic [1:0] REG_KIND    = 2'd2;
  localparam logic [1:0] REG_INNER   = 2'd3;

  localparam logic [2:0] S_FILL   = 3'd0;
  localparam logic [2:0] S_ALIGN  = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_EMIT   = 3'd3;
  localparam logic [2:0] S_PASS   = 3'd4;
  localparam logic [2:0] S_DRAIN  = 3'd5;

  localparam logic [5:0] HDR_LAST = 6'(HDR_BYTES - 1);

  logic [2:0]  state;
  logic [5:0]  count;      // header words taken, later idle shifts left
  logic [5:0]  remain;     // words still to emit from the row
  logic        vld;
  logic        pkt_last;
  logic        pass_last;
  logic        st_flag;
  logic [31:0] seq;
  logic [31:0] sec;
  logic [19:0] usec;
  byte_t       prefix0, prefix1, kind, inner;

  logic         in_acc, out_acc;
  logic         stamp_hit;
  logic [15:0]  plen;
  logic [31:0]  seq_inc, seq_next;
  chain_ctl_t   ctl;
  chain_mask_t  load_en;
  chain_bytes_t load_val;
  chain_bytes_t cell_q;

  assign in_stall  = (state == S_FILL) ? 1'b0 :
                     (state == S_PASS) ? (vld & out_stall) : 1'b1;
  assign in_acc    = in_valid & ~in_stall;
  assign out_valid = vld;
  assign out_acc   = vld & ~out_stall;
  assign out_byte  = cell_q[0];
  assign out_last  = (state == S_EMIT) ? (pkt_last & (remain == 6'd1)) : pass_last;
  assign stamped   = st_flag;

  // Stamp decision on the completed header
  assign stamp_hit = (cell_q[0][7:4] == 4'h6) && (cell_q[24] == prefix0) &&
                     (cell_q[25] == prefix1) && (cell_q[6] != NH_DSTOPT);
  assign plen      = {cell_q[4], cell_q[5]} + 16'(OPT_BYTES);
  assign seq_inc   = seq + 32'd1;
  assign seq_next  = (seq_inc == 32'hffff_ffff) ? 32'd0 : seq_inc;

  always_comb begin
    ctl.fill  = (state == S_FILL);
    ctl.shift = (state == S_FILL && in_acc) || (state == S_ALIGN) ||
                (state == S_EMIT && out_acc);
    load_en   = '0;
    load_val  = '0;
    if (state == S_PASS && in_acc) begin
      load_en[0]  = 1'b1;
      load_val[0] = data_byte;
    end
    if (state == S_DECIDE && stamp_hit) begin
      load_en[4]  = 1'b1;
      load_val[4] = plen[15:8];
      load_en[5]  = 1'b1;
      load_val[5] = plen[7:0];
      load_en[6]  = 1'b1;
      load_val[6] = NH_DSTOPT;
      for (int i = HDR_BYTES; i < CHAIN_CELLS; i++) begin
        load_en[i] = 1'b1;
      end
      load_val[HDR_BYTES+0]  = inner;
      load_val[HDR_BYTES+1]  = OPT_HDR_LEN;
      load_val[HDR_BYTES+2]  = kind;
      load_val[HDR_BYTES+3]  = OPT_LEN;
      load_val[HDR_BYTES+4]  = seq_next[31:24];
      load_val[HDR_BYTES+5]  = seq_next[23:16];
      load_val[HDR_BYTES+6]  = seq_next[15:8];
      load_val[HDR_BYTES+7]  = seq_next[7:0];
      load_val[HDR_BYTES+8]  = sec[31:24];
      load_val[HDR_BYTES+9]  = sec[23:16];
      load_val[HDR_BYTES+10] = sec[15:8];
      load_val[HDR_BYTES+11] = sec[7:0];
      load_val[HDR_BYTES+12] = 8'h00;
      load_val[HDR_BYTES+13] = {4'h0, usec[19:16]};
      load_val[HDR_BYTES+14] = usec[15:8];
      load_val[HDR_BYTES+15] = usec[7:0];
    end
  end

  ipts_chain u_chain (
    .clk       (clk),
    .ctl       (ctl),
    .fill_byte (data_byte),
    .load_en   (load_en),
    .load_val  (load_val),
    .cell_q    (cell_q)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prefix0 <= 8'hff;
      prefix1 <= 8'h15;
      kind    <= 8'h15;
      inner   <= 8'h11;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PREFIX0: prefix0 <= cfg_data;
        REG_PREFIX1: prefix1 <= cfg_data;
        REG_KIND:    kind    <= cfg_data;
        REG_INNER:   inner   <= cfg_data;
        default:     ;
      endcase
    end
  end

  // Time sample on the word completing the header
  always_ff @(posedge clk) begin
    if (state == S_FILL && in_acc && count == HDR_LAST) begin
      sec  <= time_seconds;
      usec <= time_micros;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_PASS && in_acc) begin
      pass_last <= last_byte;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_FILL;
      count    <= '0;
      remain   <= '0;
      vld      <= 1'b0;
      pkt_last <= 1'b0;
      st_flag  <= 1'b0;
      seq      <= '0;
    end else begin
      unique case (state)
        S_FILL: begin
          if (in_acc) begin
            if (count == HDR_LAST) begin
              pkt_last <= last_byte;
              count    <= '0;
              state    <= S_DECIDE;
            end else if (last_byte) begin
              // short packet: slide its first word to the head, then flush
              pkt_last <= 1'b1;
              remain   <= count + 6'd1;
              count    <= HDR_LAST - count;
              state    <= S_ALIGN;
            end else begin
              count <= count + 6'd1;
            end
          end
        end
        S_ALIGN: begin
          count <= count - 6'd1;
          if (count == 6'd1) begin
            count <= '0;
            vld   <= 1'b1;
            state <= S_EMIT;
          end
        end
        S_DECIDE: begin
          st_flag <= stamp_hit;
          remain  <= stamp_hit ? 6'(CHAIN_CELLS) : 6'(HDR_BYTES);
          if (stamp_hit) begin
            seq <= seq_next;
          end
          vld   <= 1'b1;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_acc) begin
            remain <= remain - 6'd1;
            if (remain == 6'd1) begin
              vld <= 1'b0;
              if (pkt_last) begin
                st_flag  <= 1'b0;
                pkt_last <= 1'b0;
                state    <= S_FILL;
              end else begin
                state <= S_PASS;
              end
            end
          end
        end
        S_PASS: begin
          if (in_acc) begin
            vld <= 1'b1;
            if (last_byte) begin
              state <= S_DRAIN;
            end
          end else if (out_acc) begin
            vld <= 1'b0;
          end
        end
        S_DRAIN: begin
          if (out_acc) begin
            vld     <= 1'b0;
            st_flag <= 1'b0;
            state   <= S_FILL;
          end
        end
        default: begin
          state <= S_FILL;
        end
      endcase
    end
  end

endmodule

### tb/ipv6_timestamp_option_inserter_tb.sv
`timescale 1ns / 100ps

module ipv6_timestamp_option_inserter_tb;
  import ipts_pkg::*;

  // Register map of the configuration port
  localparam logic [1:0] REG_PREFIX_FIRST  = 2'd0;
  localparam logic [1:0] REG_PREFIX_SECOND = 2'd1;
  localparam logic [1:0] REG_OPTION_KIND   = 2'd2;
  localparam logic [1:0] REG_INNER_NH      = 2'd3;

  // Header capture plus decision plus 56 words out, with margin
  localparam int SETTLE_CYCLES  = 120;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_WORDS   = 40;

  // Where the time fields of a packet's words come from
  typedef enum int {TM_RANDOM, TM_ZERO, TM_ONES} time_mode_e;

  typedef struct {
    byte_t       data;
    logic        last;
    logic [31:0] secs;
    logic [19:0] usecs;
  } pkt_word_t;

  typedef struct {
    byte_t data;
    logic  last;
    logic  stamped;
  } out_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = '0;
  logic        last_byte = 1'b0;
  logic [31:0] time_seconds = '0;
  logic [19:0] time_micros = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        stamped;

  ipv6_timestamp_option_inserter u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .time_seconds (time_seconds),
    .time_micros  (time_micros),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .stamped      (stamped)
  );

  always #6 clk = ~clk;

  // Words waiting for the driver, and bytes the block owes us
  pkt_word_t pending_words [$];
  out_beat_t expected_bytes [$];
  int        words_loaded = 0;
  int        words_taken = 0;
  int        error_count = 0;

  // Configuration as the block holds it; only changed while it is idle
  byte_t cfg_pfx_first  = 8'hff;
  byte_t cfg_pfx_second = 8'h15;
  byte_t cfg_kind       = 8'h15;
  byte_t cfg_inner      = 8'h11;

  // Predictor state: captured fixed header, fill position, stamp counter
  byte_t       hdr_buf [HDR_BYTES];
  int          hdr_pos = 0;
  logic [31:0] seq_num = '0;
  logic        cur_stamped = 1'b0;

  // Header under construction by the stimulus code
  byte_t hdr_draft [HDR_BYTES];

  // Work out what one accepted input word makes the block emit.
  // Header words are held back until the 40th; then the whole header (and
  // the option block when stamped) is owed. Later words pass straight through.
  task automatic predict_stamped_stream(input pkt_word_t w);
    logic [15:0]  plen;
    logic [127:0] opt_vec;
    logic         st;
    int           total;
    int           i;
    out_beat_t    beat;
    if (hdr_pos >= HDR_BYTES) begin
      beat = '{w.data, w.last, cur_stamped};
      expected_bytes.push_back(beat);
      if (w.last) begin
        hdr_pos = 0;
        cur_stamped = 1'b0;
      end
      return;
    end
    hdr_buf[hdr_pos] = w.data;
    hdr_pos++;
    if (hdr_pos < HDR_BYTES) begin
      // Short packet: flush what was held, never stamped
      if (w.last) begin
        for (i = 0; i < hdr_pos; i++) begin
          beat = '{hdr_buf[i], i == hdr_pos - 1, 1'b0};
          expected_bytes.push_back(beat);
        end
        hdr_pos = 0;
        cur_stamped = 1'b0;
      end
      return;
    end
    st = (hdr_buf[0][7:4] == 4'h6) && (hdr_buf[24] == cfg_pfx_first) &&
         (hdr_buf[25] == cfg_pfx_second) && (hdr_buf[6] != NH_DSTOPT);
    opt_vec = '0;
    if (st) begin
      plen = {hdr_buf[4], hdr_buf[5]} + 16'(OPT_BYTES);
      hdr_buf[4] = plen[15:8];
      hdr_buf[5] = plen[7:0];
      hdr_buf[6] = NH_DSTOPT;
      // Pre-increment; the all-ones value is skipped by going to zero
      seq_num = seq_num + 32'd1;
      if (seq_num == 32'hffff_ffff) seq_num = '0;
      opt_vec = {cfg_inner, OPT_HDR_LEN, cfg_kind, OPT_LEN, seq_num, w.secs,
                 12'h000, w.usecs};
    end
    total = HDR_BYTES + (st ? OPT_BYTES : 0);
    for (i = 0; i < total; i++) begin
      if (i < HDR_BYTES) beat.data = hdr_buf[i];
      else beat.data = opt_vec[127 - 8 * (i - HDR_BYTES) -: 8];
      beat.last = w.last && (i == total - 1);
      beat.stamped = st;
      expected_bytes.push_back(beat);
    end
    hdr_pos = w.last ? 0 : HDR_BYTES;
    cur_stamped = w.last ? 1'b0 : st;
  endtask

  // Random header; when aimed, make it pass every stamping test
  task automatic draft_header(input bit aim);
    int i;
    for (i = 0; i < HDR_BYTES; i++) hdr_draft[i] = 8'($urandom_range(0, 255));
    if (aim) begin
      hdr_draft[0][7:4] = 4'h6;
      hdr_draft[24] = cfg_pfx_first;
      hdr_draft[25] = cfg_pfx_second;
      if (hdr_draft[6] == NH_DSTOPT) hdr_draft[6] = hdr_draft[6] ^ 8'h01;
    end
  endtask

  // Queue one packet of n_words: the drafted header, then random payload
  task automatic load_packet(input int n_words, input time_mode_e tmode);
    pkt_word_t w;
    int        i;
    for (i = 0; i < n_words; i++) begin
      w.data = (i < HDR_BYTES) ? hdr_draft[i] : 8'($urandom_range(0, 255));
      w.last = (i == n_words - 1);
      case (tmode)
        TM_ZERO: begin
          w.secs = '0;
          w.usecs = '0;
        end
        TM_ONES: begin
          w.secs = 32'hffff_ffff;
          w.usecs = 20'hfffff;
        end
        default: begin
          w.secs = $urandom;
          // Half the time legal microseconds, else the full 20-bit range
          w.usecs = ($urandom_range(0, 1) == 0) ? 20'($urandom_range(0, 999999))
                                                : 20'($urandom_range(0, 20'hfffff));
        end
      endcase
      pending_words.push_back(w);
      words_loaded++;
    end
  endtask

  // Mostly well-formed stamp candidates, some near misses, noise and runts
  task automatic random_traffic(input int word_goal);
    int queued;
    int r;
    int n;
    queued = 0;
    while (queued < word_goal) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        draft_header(1'b1);
        if (r < 6) hdr_draft[6] = NH_DSTOPT;
        else if (r < 12) hdr_draft[24 + r % 2] ^= 8'(1 << $urandom_range(0, 7));
        else if (r < 16) hdr_draft[0][7:4] = 4'($urandom_range(0, 15));
        else if (r < 22) hdr_draft[4] = 8'hff;
        n = HDR_BYTES + $urandom_range(0, 8);
      end else if (r < 85) begin
        draft_header(1'b0);
        n = HDR_BYTES + $urandom_range(0, 4);
      end else begin
        draft_header(1'($urandom_range(0, 1)));
        n = $urandom_range(1, HDR_BYTES - 1);
      end
      load_packet(n, TM_RANDOM);
      queued += n;
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input byte_t val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  // Only called with the block idle, so the model copy can change at once
  task automatic set_config(input byte_t pfx_first, input byte_t pfx_second,
                            input byte_t kind, input byte_t inner);
    write_reg(REG_PREFIX_FIRST, pfx_first);
    write_reg(REG_PREFIX_SECOND, pfx_second);
    write_reg(REG_OPTION_KIND, kind);
    write_reg(REG_INNER_NH, inner);
    @(negedge clk);
    cfg_write <= 1'b0;
    cfg_pfx_first  = pfx_first;
    cfg_pfx_second = pfx_second;
    cfg_kind       = kind;
    cfg_inner      = inner;
  endtask

  // Wait until every word is taken and every owed byte has come, then
  // let the block's pipeline run dry
  task automatic settle();
    do @(negedge clk);
    while (pending_words.size() != 0 || words_taken != words_loaded ||
           expected_bytes.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Sender: bursts of words separated by random gaps. A word is held
  // until the edge that takes it; only then advance.
  logic      in_took = 1'b0;
  int        burst_left = 0;
  int        gap_left = 0;
  pkt_word_t send_word;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (pending_words.size() != 0) begin
        send_word = pending_words.pop_front();
        in_valid     <= 1'b1;
        data_byte    <= send_word.data;
        last_byte    <= send_word.last;
        time_seconds <= send_word.secs;
        time_micros  <= send_word.usecs;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 48);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: switch at random between no stall, random stall and a
  // periodic stall pattern
  int stall_mode = 0;
  int stall_mode_left = 0;
  int stall_tick = 0;

  always @(negedge clk) begin
    if (stall_mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_mode_left = $urandom_range(20, 80);
    end else begin
      stall_mode_left--;
    end
    stall_tick++;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= ((stall_tick % 16) < 7);
    endcase
  end

  // Monitor: predict on every word taken, check every byte delivered,
  // and give up if the handshakes stop moving
  out_beat_t due_beat;
  int        idle_cycles = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_took <= 1'b0;
      idle_cycles = 0;
    end else begin
      in_took <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        words_taken++;
        predict_stamped_stream('{data_byte, last_byte, time_seconds, time_micros});
      end
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          $error("output word with nothing owed: out_byte %h out_last %b stamped %b",
                 out_byte, out_last, stamped);
          error_count++;
        end else begin
          due_beat = expected_bytes.pop_front();
          if (out_byte !== due_beat.data) begin
            $error("out_byte expected %h actual %h", due_beat.data, out_byte);
            error_count++;
          end
          if (out_last !== due_beat.last) begin
            $error("out_last expected %b actual %b", due_beat.last, out_last);
            error_count++;
          end
          if (stamped !== due_beat.stamped) begin
            $error("stamped expected %b actual %b", due_beat.stamped, stamped);
            error_count++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("ipv6_timestamp_option_inserter test failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset register values. A one-word runt first.
    draft_header(1'b0);
    hdr_draft[0] = 8'hff;
    load_packet(1, TM_ONES);
    // Header only, stamped, payload length wraps, packet ends on the header
    draft_header(1'b1);
    hdr_draft[4] = 8'hff;
    hdr_draft[5] = 8'hf5;
    load_packet(HDR_BYTES, TM_ONES);
    // Already carries destination options: pass untouched
    draft_header(1'b1);
    hdr_draft[6] = NH_DSTOPT;
    load_packet(HDR_BYTES + 1, TM_RANDOM);
    settle();

    // All registers at zero, stamped with zero payload length
    set_config(8'h00, 8'h00, 8'h00, 8'h00);
    draft_header(1'b1);
    hdr_draft[0] = 8'h60;
    hdr_draft[4] = 8'h00;
    hdr_draft[5] = 8'h00;
    load_packet(HDR_BYTES + 2, TM_ONES);
    settle();

    // Random setting
    set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    random_traffic(RANDOM_WORDS);
    settle();

    if (error_count == 0) begin
      $display("ipv6_timestamp_option_inserter test passed");
    end else begin
      $display("ipv6_timestamp_option_inserter test failed");
    end
    $finish;
  end

endmodule
